FILE: hdl/sphere_circumcenter_vertex_macros.svh
// Assertion helpers, clocked on clk, off while rst_n is low.
`ifndef SPHERE_CIRCUMCENTER_VERTEX_MACROS_SVH
`define SPHERE_CIRCUMCENTER_VERTEX_MACROS_SVH

// same-cycle implication
`define SCV_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scv check failed");

// next-cycle implication
`define SCV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scv check failed");

`endif

FILE: hdl/scv_pkg.sv
`default_nettype none
package scv_pkg;

  localparam int FRAC_BITS = 14;

  localparam int CW    = 16;               // corner coordinate
  localparam int XW    = 33;               // cross product term
  localparam int SW    = 34;               // squared length, a.b
  localparam int PW    = 49;               // a_i * t_i
  localparam int DETW  = 51;               // determinant
  localparam int UW    = 67;               // |x|^2 * cross
  localparam int NW    = 34;               // degenerate normal
  localparam int DDW   = 17;               // a - b
  localparam int VPW   = 51;               // n_j * d_k
  localparam int DW    = 68;               // signed direction
  localparam int MW    = 67;               // direction magnitude
  localparam int GRP   = 9;                // byte groups for the length search
  localparam int GW    = 8 * GRP;
  localparam int GIW   = 4;
  localparam int LW    = 7;                // bit length of the largest magnitude
  localparam int NB    = 30;               // normalized magnitude bits
  localparam int SQW   = 2 * NB + 2;       // sum of squares
  localparam int SQ_STEPS = SQW / 2;       // one root bit per stage
  localparam int NRM_W = SQ_STEPS;         // norm width
  localparam int RW    = NRM_W + 4;        // root remainder
  localparam int QW    = FRAC_BITS + 1;    // quotient bits, q <= 2^FRAC_BITS
  localparam int NUMW  = NB + FRAC_BITS + 1;
  localparam int DRW   = NRM_W + 1;        // divider remainder

  // valid-bit positions along the pipe
  localparam int V_SQ0 = 10;
  localparam int V_NUM = V_SQ0 + SQ_STEPS;
  localparam int V_DV0 = V_NUM + 1;
  localparam int NSTG  = V_DV0 + QW;

  localparam logic signed [63:0] AB_UNIT_NEG = -(64'sd1 <<< (2 * FRAC_BITS));
  localparam logic [QW-1:0]      Q_MAX       = QW'(1) << FRAC_BITS;
  localparam logic [31:0]        Q_CLAMP     = 32'd65536;

  // p*q - r*s
  function automatic logic signed [XW-1:0] xterm(input logic signed [CW-1:0] p,
                                                 input logic signed [CW-1:0] q,
                                                 input logic signed [CW-1:0] r,
                                                 input logic signed [CW-1:0] s);
    logic signed [2*CW-1:0] m0;
    logic signed [2*CW-1:0] m1;
    m0 = p * q;
    m1 = r * s;
    return XW'(m0) - XW'(m1);
  endfunction

  function automatic logic signed [SW-1:0] dot3(input logic signed [CW-1:0] p0,
                                                input logic signed [CW-1:0] p1,
                                                input logic signed [CW-1:0] p2,
                                                input logic signed [CW-1:0] q0,
                                                input logic signed [CW-1:0] q1,
                                                input logic signed [CW-1:0] q2);
    logic signed [2*CW-1:0] m0;
    logic signed [2*CW-1:0] m1;
    logic signed [2*CW-1:0] m2;
    m0 = p0 * q0;
    m1 = p1 * q1;
    m2 = p2 * q2;
    return SW'(m0) + SW'(m1) + SW'(m2);
  endfunction

  function automatic logic [3:0] bitlen8(input logic [7:0] b);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) n = 4'(i + 1);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/sphere_circumcenter_vertex.sv
// Spherical Voronoi vertex: unit circumcenter direction of one hull triangle.
// Input channel in_*: one word per triangle, in_tdata carries the nine corner
// coordinates a, b, c (Q1.14 signed). Result channel out_*: one word per
// triangle, out_tdata carries the unit direction, out_tuser[0] is no_solution
// (set when no direction exists; the center is then all zero).
// Fully pipelined: a new triangle is taken every cycle while in_tready is high.
// The pipe runs ten stages of products, sums, the leading-bit search and the
// normalizing shift, then the 31-stage square root (one root bit per stage)
// and the FRAC_BITS+1-stage restoring divider (one quotient bit per stage).
// Reset (rst_n low, synchronous) clears all valid bits; nothing is in flight.
// When the receiver stalls, the output word holds and the pipe keeps moving
// until a finished word reaches the stage in front of the output register;
// only then does in_tready drop. Nothing is lost or repeated.
`default_nettype none
`include "sphere_circumcenter_vertex_macros.svh"

module sphere_circumcenter_vertex (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [143:0] in_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [47:0]  out_tdata,  // center_x, center_y, center_z
  output logic [0:0]   out_tuser   // no_solution
);

  // ---------------- pipe control ----------------
  logic [scv_pkg::NSTG-1:0] v_r;
  logic                     out_valid_r;
  logic                     out_ld;
  logic                     pipe_en;

  assign out_ld    = !out_valid_r || out_tready;
  assign pipe_en   = out_ld || !v_r[scv_pkg::NSTG-1];
  assign in_tready = pipe_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pipe_en) v_r <= {v_r[scv_pkg::NSTG-2:0], in_tvalid};
      if (out_ld) out_valid_r <= v_r[scv_pkg::NSTG-1];
    end
  end

  // ---------------- S1: cross products, squared lengths ----------------
  logic signed [scv_pkg::CW-1:0] ia [3];
  logic signed [scv_pkg::CW-1:0] ib [3];
  logic signed [scv_pkg::CW-1:0] ic [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ia[i] = signed'(in_tdata[16*i +: 16]);
      ib[i] = signed'(in_tdata[16*(3+i) +: 16]);
      ic[i] = signed'(in_tdata[16*(6+i) +: 16]);
    end
  end

  logic signed [scv_pkg::CW-1:0] a1_r [3];
  logic signed [scv_pkg::CW-1:0] b1_r [3];
  logic signed [scv_pkg::CW-1:0] c1_r [3];
  logic signed [scv_pkg::XW-1:0] t1_r [3];    // b x c
  logic signed [scv_pkg::XW-1:0] c31_1_r [3]; // c x a
  logic signed [scv_pkg::XW-1:0] c12_1_r [3]; // a x b
  logic signed [scv_pkg::SW-1:0] sa1_r, sb1_r, sc1_r, ab1_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) begin
        a1_r[i]    <= ia[i];
        b1_r[i]    <= ib[i];
        c1_r[i]    <= ic[i];
        t1_r[i]    <= scv_pkg::xterm(ib[(i+1)%3], ic[(i+2)%3], ib[(i+2)%3], ic[(i+1)%3]);
        c31_1_r[i] <= scv_pkg::xterm(ic[(i+1)%3], ia[(i+2)%3], ic[(i+2)%3], ia[(i+1)%3]);
        c12_1_r[i] <= scv_pkg::xterm(ia[(i+1)%3], ib[(i+2)%3], ia[(i+2)%3], ib[(i+1)%3]);
      end
      sa1_r <= scv_pkg::dot3(ia[0], ia[1], ia[2], ia[0], ia[1], ia[2]);
      sb1_r <= scv_pkg::dot3(ib[0], ib[1], ib[2], ib[0], ib[1], ib[2]);
      sc1_r <= scv_pkg::dot3(ic[0], ic[1], ic[2], ic[0], ic[1], ic[2]);
      ab1_r <= scv_pkg::dot3(ia[0], ia[1], ia[2], ib[0], ib[1], ib[2]);
    end
  end

  // ---------------- S2: products for det, usual and degenerate case ------
  logic signed [scv_pkg::PW-1:0]  dp_nxt [3];
  logic signed [scv_pkg::UW-1:0]  u_nxt [3][3];
  logic signed [scv_pkg::NW-1:0]  n_nxt [3];
  logic signed [scv_pkg::DDW-1:0] d_nxt [3];
  logic                           swap;

  always_comb begin
    // a.b == -1 exactly: c stands in for b, and a x c = -(c x a)
    swap = (64'(ab1_r) == scv_pkg::AB_UNIT_NEG);
    for (int i = 0; i < 3; i++) begin
      dp_nxt[i]   = a1_r[i] * t1_r[i];
      u_nxt[i][0] = sa1_r * t1_r[i];
      u_nxt[i][1] = sb1_r * c31_1_r[i];
      u_nxt[i][2] = sc1_r * c12_1_r[i];
      n_nxt[i]    = swap ? -scv_pkg::NW'(c31_1_r[i]) : scv_pkg::NW'(c12_1_r[i]);
      d_nxt[i]    = scv_pkg::DDW'(a1_r[i]) - scv_pkg::DDW'(swap ? c1_r[i] : b1_r[i]);
    end
  end

  logic signed [scv_pkg::PW-1:0]  dp2_r [3];
  logic signed [scv_pkg::UW-1:0]  u2_r [3][3];
  logic signed [scv_pkg::NW-1:0]  n2_r [3];
  logic signed [scv_pkg::DDW-1:0] d2_r [3];

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      dp2_r <= dp_nxt;
      u2_r  <= u_nxt;
      n2_r  <= n_nxt;
      d2_r  <= d_nxt;
    end
  end

  // ---------------- S3: det sum, usual sums, n x d products ----------------
  logic signed [scv_pkg::DETW-1:0] det3_r;
  logic signed [scv_pkg::DW-1:0]   w3_r [3];
  logic signed [scv_pkg::VPW-1:0]  vp3_r [3][2];

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      det3_r <= scv_pkg::DETW'(dp2_r[0]) + scv_pkg::DETW'(dp2_r[1])
              + scv_pkg::DETW'(dp2_r[2]);
      for (int i = 0; i < 3; i++) begin
        w3_r[i] <= scv_pkg::DW'(u2_r[i][0]) + scv_pkg::DW'(u2_r[i][1])
                 + scv_pkg::DW'(u2_r[i][2]);
        vp3_r[i][0] <= n2_r[(i+1)%3] * d2_r[(i+2)%3];
        vp3_r[i][1] <= n2_r[(i+2)%3] * d2_r[(i+1)%3];
      end
    end
  end

  // ---------------- S4: pick the direction ----------------
  logic signed [scv_pkg::DW-1:0] dir4_r [3];

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) begin
        if (det3_r == '0) begin
          dir4_r[i] <= scv_pkg::DW'(vp3_r[i][0]) - scv_pkg::DW'(vp3_r[i][1]);
        end else if (det3_r[scv_pkg::DETW-1]) begin
          dir4_r[i] <= -w3_r[i];
        end else begin
          dir4_r[i] <= w3_r[i];
        end
      end
    end
  end

  // ---------------- S5: sign and magnitude ----------------
  logic [scv_pkg::MW-1:0] mag5_r [3];
  logic [2:0]             neg5_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) begin
        neg5_r[i] <= dir4_r[i][scv_pkg::DW-1];
        mag5_r[i] <= dir4_r[i][scv_pkg::DW-1] ? scv_pkg::MW'(-dir4_r[i])
                                              : scv_pkg::MW'(dir4_r[i]);
      end
    end
  end

  // ---------------- S6: highest nonzero byte of the OR of magnitudes -------
  logic [scv_pkg::GW-1:0]  orw;
  logic [scv_pkg::GIW-1:0] gi_nxt;

  always_comb begin
    orw    = scv_pkg::GW'(mag5_r[0] | mag5_r[1] | mag5_r[2]);
    gi_nxt = '0;
    for (int g = 0; g < scv_pkg::GRP; g++) begin
      if (orw[8*g +: 8] != '0) gi_nxt = scv_pkg::GIW'(g);
    end
  end

  logic [scv_pkg::GIW-1:0] gi6_r;
  logic [7:0]              byte6_r;
  logic [scv_pkg::MW-1:0]  mag6_r [3];
  logic [2:0]              neg6_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      gi6_r   <= gi_nxt;
      byte6_r <= orw[8*gi_nxt +: 8];
      mag6_r  <= mag5_r;
      neg6_r  <= neg5_r;
    end
  end

  // ---------------- S7: bit length ----------------
  logic [scv_pkg::LW-1:0] l7_r;
  logic [scv_pkg::MW-1:0] mag7_r [3];
  logic [2:0]             neg7_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      l7_r   <= {gi6_r, 3'b000} + scv_pkg::LW'(scv_pkg::bitlen8(byte6_r));
      mag7_r <= mag6_r;
      neg7_r <= neg6_r;
    end
  end

  // ---------------- S8: common shift to NB significant bits ----------------
  logic [scv_pkg::NB-1:0] m_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (l7_r > scv_pkg::LW'(scv_pkg::NB)) begin
        m_nxt[i] = scv_pkg::NB'(mag7_r[i] >> (l7_r - scv_pkg::LW'(scv_pkg::NB)));
      end else begin
        m_nxt[i] = scv_pkg::NB'(mag7_r[i] << (scv_pkg::LW'(scv_pkg::NB) - l7_r));
      end
    end
  end

  logic [scv_pkg::NB-1:0] m8_r [3];
  logic [2:0]             neg8_r;
  logic                   zero8_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      m8_r    <= m_nxt;
      neg8_r  <= neg7_r;
      zero8_r <= (l7_r == '0);
    end
  end

  // ---------------- S9/S10: sum of squares ----------------
  logic [2*scv_pkg::NB-1:0] sq9_r [3];
  logic [scv_pkg::NB-1:0]   m9_r [3];
  logic [2:0]               neg9_r;
  logic                     zero9_r;
  logic [scv_pkg::SQW-1:0]  s10_r;
  logic [scv_pkg::NB-1:0]   m10_r [3];
  logic [2:0]               neg10_r;
  logic                     zero10_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) sq9_r[i] <= m8_r[i] * m8_r[i];
      m9_r     <= m8_r;
      neg9_r   <= neg8_r;
      zero9_r  <= zero8_r;
      s10_r    <= scv_pkg::SQW'(sq9_r[0]) + scv_pkg::SQW'(sq9_r[1])
                + scv_pkg::SQW'(sq9_r[2]);
      m10_r    <= m9_r;
      neg10_r  <= neg9_r;
      zero10_r <= zero9_r;
    end
  end

  // ---------------- square root, one result bit per stage ----------------
  logic [scv_pkg::RW-1:0]    sq_rem_r  [scv_pkg::SQ_STEPS];
  logic [scv_pkg::NRM_W-1:0] sq_root_r [scv_pkg::SQ_STEPS];
  logic [scv_pkg::SQW-1:0]   sq_src_r  [scv_pkg::SQ_STEPS];
  logic [scv_pkg::NB-1:0]    sq_m_r    [scv_pkg::SQ_STEPS][3];
  logic [2:0]                sq_neg_r  [scv_pkg::SQ_STEPS];
  logic                      sq_zero_r [scv_pkg::SQ_STEPS];

  logic [scv_pkg::RW-1:0]    sq_rem_nxt  [scv_pkg::SQ_STEPS];
  logic [scv_pkg::NRM_W-1:0] sq_root_nxt [scv_pkg::SQ_STEPS];
  logic [scv_pkg::SQW-1:0]   sq_src_nxt  [scv_pkg::SQ_STEPS];

  always_comb begin
    logic [scv_pkg::RW-1:0]    rem_in;
    logic [scv_pkg::NRM_W-1:0] root_in;
    logic [scv_pkg::SQW-1:0]   src_in;
    logic [scv_pkg::RW-1:0]    rsh;
    logic [scv_pkg::RW-1:0]    trial;
    for (int k = 0; k < scv_pkg::SQ_STEPS; k++) begin
      if (k == 0) begin
        rem_in  = '0;
        root_in = '0;
        src_in  = s10_r;
      end else begin
        rem_in  = sq_rem_r[k-1];
        root_in = sq_root_r[k-1];
        src_in  = sq_src_r[k-1];
      end
      rsh   = scv_pkg::RW'({rem_in, src_in[scv_pkg::SQW-1 -: 2]});
      trial = scv_pkg::RW'({root_in, 2'b01});
      if (rsh >= trial) begin
        sq_rem_nxt[k]  = rsh - trial;
        sq_root_nxt[k] = {root_in[scv_pkg::NRM_W-2:0], 1'b1};
      end else begin
        sq_rem_nxt[k]  = rsh;
        sq_root_nxt[k] = {root_in[scv_pkg::NRM_W-2:0], 1'b0};
      end
      sq_src_nxt[k] = {src_in[scv_pkg::SQW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sq_rem_r  <= sq_rem_nxt;
      sq_root_r <= sq_root_nxt;
      sq_src_r  <= sq_src_nxt;
      sq_m_r[0]    <= m10_r;
      sq_neg_r[0]  <= neg10_r;
      sq_zero_r[0] <= zero10_r;
      for (int k = 1; k < scv_pkg::SQ_STEPS; k++) begin
        sq_m_r[k]    <= sq_m_r[k-1];
        sq_neg_r[k]  <= sq_neg_r[k-1];
        sq_zero_r[k] <= sq_zero_r[k-1];
      end
    end
  end

  // ---------------- numerator: m * 2^F + norm/2 ----------------
  logic [scv_pkg::NRM_W-1:0] norm_w;
  logic [scv_pkg::NUMW-1:0]  num_w [3];

  always_comb begin
    norm_w = sq_root_r[scv_pkg::SQ_STEPS-1];
    for (int i = 0; i < 3; i++) begin
      num_w[i] = (scv_pkg::NUMW'(sq_m_r[scv_pkg::SQ_STEPS-1][i]) << scv_pkg::FRAC_BITS)
               + scv_pkg::NUMW'(norm_w >> 1);
    end
  end

  logic [scv_pkg::DRW-1:0]   nm_rem_r [3];
  logic [scv_pkg::QW-1:0]    nm_low_r [3];
  logic [scv_pkg::NRM_W-1:0] nm_norm_r;
  logic [2:0]                nm_neg_r;
  logic                      nm_zero_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) begin
        nm_rem_r[i] <= scv_pkg::DRW'(num_w[i] >> scv_pkg::QW);
        nm_low_r[i] <= scv_pkg::QW'(num_w[i]);
      end
      nm_norm_r <= norm_w;
      nm_neg_r  <= sq_neg_r[scv_pkg::SQ_STEPS-1];
      nm_zero_r <= sq_zero_r[scv_pkg::SQ_STEPS-1];
    end
  end

  // ---------------- restoring divider, one quotient bit per stage ---------
  // low holds the unused numerator bits, quotient bits shift in behind them
  logic [scv_pkg::DRW-1:0]   dv_rem_r  [scv_pkg::QW][3];
  logic [scv_pkg::QW-1:0]    dv_low_r  [scv_pkg::QW][3];
  logic [scv_pkg::NRM_W-1:0] dv_norm_r [scv_pkg::QW];
  logic [2:0]                dv_neg_r  [scv_pkg::QW];
  logic                      dv_zero_r [scv_pkg::QW];

  logic [scv_pkg::DRW-1:0]   dv_rem_nxt [scv_pkg::QW][3];
  logic [scv_pkg::QW-1:0]    dv_low_nxt [scv_pkg::QW][3];

  always_comb begin
    logic [scv_pkg::DRW-1:0]   rem_in;
    logic [scv_pkg::QW-1:0]    low_in;
    logic [scv_pkg::NRM_W-1:0] nrm_in;
    logic [scv_pkg::DRW-1:0]   rsh;
    for (int j = 0; j < scv_pkg::QW; j++) begin
      for (int i = 0; i < 3; i++) begin
        if (j == 0) begin
          rem_in = nm_rem_r[i];
          low_in = nm_low_r[i];
          nrm_in = nm_norm_r;
        end else begin
          rem_in = dv_rem_r[j-1][i];
          low_in = dv_low_r[j-1][i];
          nrm_in = dv_norm_r[j-1];
        end
        rsh = {rem_in[scv_pkg::DRW-2:0], low_in[scv_pkg::QW-1]};
        if (rsh >= scv_pkg::DRW'(nrm_in)) begin
          dv_rem_nxt[j][i] = rsh - scv_pkg::DRW'(nrm_in);
          dv_low_nxt[j][i] = {low_in[scv_pkg::QW-2:0], 1'b1};
        end else begin
          dv_rem_nxt[j][i] = rsh;
          dv_low_nxt[j][i] = {low_in[scv_pkg::QW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      dv_rem_r <= dv_rem_nxt;
      dv_low_r <= dv_low_nxt;
      dv_norm_r[0] <= nm_norm_r;
      dv_neg_r[0]  <= nm_neg_r;
      dv_zero_r[0] <= nm_zero_r;
      for (int j = 1; j < scv_pkg::QW; j++) begin
        dv_norm_r[j] <= dv_norm_r[j-1];
        dv_neg_r[j]  <= dv_neg_r[j-1];
        dv_zero_r[j] <= dv_zero_r[j-1];
      end
    end
  end

  // ---------------- sign, saturation, output register ----------------
  logic signed [15:0] ctr_nxt [3];

  always_comb begin
    logic [31:0]        qw;
    logic signed [32:0] sv;
    for (int i = 0; i < 3; i++) begin
      qw = 32'(dv_low_r[scv_pkg::QW-1][i]);
      if (qw > scv_pkg::Q_CLAMP) qw = scv_pkg::Q_CLAMP;
      sv = dv_neg_r[scv_pkg::QW-1][i] ? -signed'({1'b0, qw}) : signed'({1'b0, qw});
      if (dv_zero_r[scv_pkg::QW-1]) begin
        ctr_nxt[i] = '0;
      end else if (sv > 33'sd32767) begin
        ctr_nxt[i] = 16'sh7fff;
      end else if (sv < -33'sd32768) begin
        ctr_nxt[i] = 16'sh8000;
      end else begin
        ctr_nxt[i] = 16'(sv);
      end
    end
  end

  logic signed [15:0] ctr_r [3];
  logic               nosol_r;

  always_ff @(posedge clk) begin
    if (out_ld) begin
      ctr_r   <= ctr_nxt;
      nosol_r <= dv_zero_r[scv_pkg::QW-1];
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {ctr_r[2], ctr_r[1], ctr_r[0]};
  assign out_tuser[0] = nosol_r;

  // ---------------- checks ----------------
  `SCV_ASSERT_NOW(a_stall_only_when_full, !in_tready, out_tvalid && v_r[scv_pkg::NSTG-1])
  `SCV_ASSERT_NOW(a_norm_msb, v_r[7] && !zero8_r, m8_r[0][scv_pkg::NB-1] || m8_r[1][scv_pkg::NB-1] || m8_r[2][scv_pkg::NB-1])
  `SCV_ASSERT_NOW(a_norm_nonzero, v_r[scv_pkg::V_NUM] && !nm_zero_r, nm_norm_r != '0)
  `SCV_ASSERT_NOW(a_quot_bound, v_r[scv_pkg::NSTG-1] && !dv_zero_r[scv_pkg::QW-1], dv_low_r[scv_pkg::QW-1][0] <= scv_pkg::Q_MAX)
  `SCV_ASSERT_NEXT(a_nosol_zero, out_ld && v_r[scv_pkg::NSTG-1] && dv_zero_r[scv_pkg::QW-1], out_tuser[0] && out_tdata == '0)

endmodule
`default_nettype wire
